// ----- rtl/bdpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdpc_pkg
// Types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

  localparam int TIME_BITS = 32;
  localparam int CFG_BITS  = 16;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_BITS-1:0]  cfg_word_t;

  // register indexes
  typedef logic [0:0] cfg_addr_t;
  localparam cfg_addr_t REG_DEB_TIME  = 1'd0;
  localparam cfg_addr_t REG_LONG_TIME = 1'd1;

  localparam cfg_word_t DEB_TIME_RST  = 16'd25;
  localparam cfg_word_t LONG_TIME_RST = 16'd600;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TAKE   = 1'b1;

  // button levels (active low)
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  // press codes
  typedef logic [1:0] press_t;
  localparam press_t PEND_NONE  = 2'd0;
  localparam press_t PEND_SHORT = 2'd1;
  localparam press_t PEND_LONG  = 2'd2;

  typedef struct packed {
    logic        kind;
    logic        level;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    press_t press;
    logic   stable_level;
  } out_word_t;

endpackage

`default_nettype wire

// ----- rtl/button_debounce_press_classifier.sv -----
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces timestamped button samples and classifies short and long presses.
// ----------------------------------------------------------------------------
// From input accept to result valid the word passes the input reg, then the result reg.
// Throughput: one word per cycle; a take word stalls only while the result
// register is full and not being taken.
// Reset: synchronous; debounced level released, timers zero, no pending press,
// debounce time 25 ms, long-press time 600 ms.
`default_nettype none

module button_debounce_press_classifier (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bdpc_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bdpc_pkg::out_word_t      out_data,
  input  wire logic                cfg_wr_en,
  input  wire bdpc_pkg::cfg_addr_t cfg_addr,
  input  wire bdpc_pkg::cfg_word_t cfg_wdata
);
  import bdpc_pkg::*;

  cfg_word_t deb_time;
  cfg_word_t long_time;

  logic   debounced_level;
  logic   last_raw_level;
  time_t  raw_change_time;
  time_t  press_start_time;
  logic   long_reported;
  press_t pending_press;

  logic     s1_valid;
  in_word_t s1_data;
  logic     s1_fire;
  logic     s1_take;

  logic   debounced_level_next;
  logic   last_raw_level_next;
  time_t  raw_change_time_next;
  time_t  press_start_time_next;
  logic   long_reported_next;
  press_t pending_press_next;

  time_t  now_t;
  time_t  raw_elapsed;
  time_t  hold_elapsed;
  logic   raw_changed;
  logic   accept_level;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      deb_time  <= DEB_TIME_RST;
      long_time <= LONG_TIME_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_DEB_TIME:  deb_time  <= cfg_wdata;
        REG_LONG_TIME: long_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  assign s1_take  = (s1_data.kind == KIND_TAKE);
  assign s1_fire  = s1_valid && (!s1_take || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // sample and take processing
  assign now_t       = TIME_BITS'(s1_data.now_ms);
  assign raw_changed = (s1_data.level != last_raw_level);
  assign raw_elapsed = now_t - raw_change_time;
  assign accept_level = (s1_data.level != debounced_level) && !raw_changed &&
                        (raw_elapsed > TIME_BITS'(deb_time));

  always_comb begin
    debounced_level_next  = debounced_level;
    last_raw_level_next   = last_raw_level;
    raw_change_time_next  = raw_change_time;
    press_start_time_next = press_start_time;
    long_reported_next    = long_reported;
    pending_press_next    = pending_press;
    if (s1_take) begin
      pending_press_next = PEND_NONE;
    end else begin
      if (raw_changed) begin
        last_raw_level_next  = s1_data.level;
        raw_change_time_next = now_t;
      end
      if (accept_level) begin
        debounced_level_next = s1_data.level;
        if (s1_data.level == LEVEL_PRESSED) begin
          press_start_time_next = now_t;
          long_reported_next    = 1'b0;
        end else if (!long_reported) begin
          pending_press_next = PEND_SHORT;
        end
      end
      if (debounced_level_next == LEVEL_PRESSED && !long_reported_next &&
          hold_elapsed >= TIME_BITS'(long_time)) begin
        long_reported_next = 1'b1;
        pending_press_next = PEND_LONG;
      end
    end
  end

  assign hold_elapsed = now_t - press_start_time_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounced_level  <= LEVEL_RELEASED;
      last_raw_level   <= LEVEL_RELEASED;
      raw_change_time  <= '0;
      press_start_time <= '0;
      long_reported    <= 1'b0;
      pending_press    <= PEND_NONE;
    end else if (s1_fire) begin
      debounced_level  <= debounced_level_next;
      last_raw_level   <= last_raw_level_next;
      raw_change_time  <= raw_change_time_next;
      press_start_time <= press_start_time_next;
      long_reported    <= long_reported_next;
      pending_press    <= pending_press_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_take) begin
      out_data.press        <= pending_press;
      out_data.stable_level <= debounced_level;
    end
  end

`ifndef SYNTHESIS
  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_take |=> pending_press == PEND_NONE)
    else $error("pending press not cleared by take");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s1_take && out_valid && !out_ready)
    else $error("input stalled without a blocked take");

  a_level_source: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (debounced_level != $past(debounced_level)) |->
      $past(s1_fire && !s1_take))
    else $error("debounced level changed without a sample");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $rose(out_valid) |-> $past(s1_fire && s1_take))
    else $error("result appeared without a take");
`endif

endmodule

`default_nettype wire
